/* hw/rtl/ple_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Capacity, derived widths, opcode and status codes, and the command word
// that the control logic broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W    = 7;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_SEARCH   = 3'd6,
    OP_SIZE     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_SEARCH = 2'd3
  } cell_op_t;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         key;
    logic [CNT_W-1:0]         count;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage : ple_pkg
`default_nettype wire

/* hw/rtl/ple_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell: one list cell
// Holds one element and takes the value of its left or right neighbor when
// an insert or a remove shifts the list. Registers a match flag on search.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_cmd_t                cmd,
  input  wire logic [IDX_W-1:0]         cell_index,
  input  wire logic signed [VAL_W-1:0]  left_value,
  input  wire logic signed [VAL_W-1:0]  right_value,
  output logic signed [VAL_W-1:0]       value,
  output logic                          match
);

  logic [CNT_W-1:0] my_index;

  assign my_index = CNT_W'(cell_index);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (my_index > cmd.key) begin
          value <= left_value;
        end else if (my_index == cmd.key) begin
          value <= cmd.value;
        end
        match <= 1'b0;
      end
      CELL_REMOVE: begin
        if (my_index >= cmd.key) begin
          value <= right_value;
        end
        match <= 1'b0;
      end
      CELL_SEARCH: begin
        // Only cells that hold a live element may report a hit.
        match <= (value == cmd.value) && (my_index < cmd.count);
      end
      default: begin
      end
    endcase
  end

endmodule : ple_cell
`default_nettype wire

/* hw/rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit values
// Inserts, deletes, searches and size queries on a list held in a row of
// shifting cells, one command transaction in, one response transaction out.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -------------------------------------
//  command   cmd_valid / cmd_ready  opcode[2:0], item_value[31:0], position[6:0]
//  response  rsp_valid / rsp_ready  status[1:0], found, count[6:0]
//
//  When a command transaction is taken, all cells shift or compare at that
//  edge. The response is formed when the pending command moves on to the
//  output register, where the registered match flags of the cells are OR-ed;
//  that move waits while the output holds a response not yet taken. A new
//  command is taken only after the pending one has moved out, and may be taken
//  while the previous response still waits in the output register; stalls on
//  the response side back up into cmd_ready. Reset clears the element count;
//  cell contents are left as they are.
module positional_list_engine
  import ple_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_ready,
  input  wire logic [2:0]               opcode,
  input  wire logic signed [VAL_W-1:0]  item_value,
  input  wire logic [POS_W-1:0]         position,
  output logic                          rsp_valid,
  input  wire logic                     rsp_ready,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [6:0]                    count
);

  // Element count and the pending response between the cells and the output.
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] element_count_next;
  logic             pend;
  logic             pend_search;
  status_t          pend_status;
  logic [CNT_W-1:0] pend_count;

  logic             accept;
  logic             move_out;
  cell_cmd_t        cmd;
  status_t          cmd_status;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     cell_match;

  assign cmd_ready = !pend;
  assign accept    = cmd_valid && cmd_ready;
  assign move_out  = pend && (!rsp_valid || rsp_ready);

  // Decode the command into a broadcast word for the cells, a status and
  // the new count. Positions are compared at a common width, so positions
  // up to 127 and every capacity compare correctly.
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic             is_full;
  logic             is_empty;

  assign pos_w    = CMP_W'(position);
  assign cnt_w    = CMP_W'(element_count);
  assign is_full  = (element_count >= CNT_W'(CAPACITY));
  assign is_empty = (element_count == '0);

  always_comb begin
    cmd.op             = CELL_HOLD;
    cmd.key            = '0;
    cmd.count          = element_count;
    cmd.value          = item_value;
    cmd_status         = ST_OK;
    element_count_next = element_count;
    case (op_t'(opcode))
      OP_INS_HEAD: begin
        if (is_full) begin
          cmd_status = ST_FULL;
        end else begin
          cmd.op             = CELL_INSERT;
          cmd.key            = '0;
          element_count_next = element_count + 1'b1;
        end
      end
      OP_INS_TAIL: begin
        if (is_full) begin
          cmd_status = ST_FULL;
        end else begin
          cmd.op             = CELL_INSERT;
          cmd.key            = element_count;
          element_count_next = element_count + 1'b1;
        end
      end
      OP_INS_POS: begin
        // Range is checked before fullness.
        if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
          cmd_status = ST_BADPOS;
        end else if (is_full) begin
          cmd_status = ST_FULL;
        end else begin
          cmd.op             = CELL_INSERT;
          cmd.key            = CNT_W'(pos_w - 1'b1);
          element_count_next = element_count + 1'b1;
        end
      end
      OP_DEL_HEAD: begin
        if (is_empty) begin
          cmd_status = ST_EMPTY;
        end else begin
          cmd.op             = CELL_REMOVE;
          cmd.key            = '0;
          element_count_next = element_count - 1'b1;
        end
      end
      OP_DEL_TAIL: begin
        // Dropping the tail only shortens the list; no cell moves.
        if (is_empty) begin
          cmd_status = ST_EMPTY;
        end else begin
          element_count_next = element_count - 1'b1;
        end
      end
      OP_DEL_POS: begin
        // An empty list has no valid position, so this also reports a bad
        // position rather than an empty list.
        if (pos_w == '0 || pos_w > cnt_w) begin
          cmd_status = ST_BADPOS;
        end else begin
          cmd.op             = CELL_REMOVE;
          cmd.key            = CNT_W'(pos_w - 1'b1);
          element_count_next = element_count - 1'b1;
        end
      end
      OP_SEARCH: begin
        cmd.op = CELL_SEARCH;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.op             = CELL_HOLD;
      element_count_next = element_count;
    end
  end

  // Row of cells; each sees its neighbors' values. The ends take their own
  // value, since what they shift in lies outside the live list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_value[i];
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end
    ple_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cell_index  (IDX_W'(i)),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .match       (cell_match[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      pend          <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      element_count <= element_count_next;
      if (accept) begin
        pend <= 1'b1;
      end else if (move_out) begin
        pend <= 1'b0;
      end
      if (move_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the pending and the output stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_search <= (op_t'(opcode) == OP_SEARCH);
      pend_status <= cmd_status;
      pend_count  <= element_count_next;
    end
    if (move_out) begin
      status <= pend_status;
      found  <= pend_search && (|cell_match);
      count  <= 7'(pend_count);
    end
  end

endmodule : positional_list_engine
`default_nettype wire
